FILE: rtl/core/jpn_pkg.sv
// ----------------------------------------------------------------------------
// jpn_pkg
// Shared types and constants for the joint pose blender.
// ----------------------------------------------------------------------------
`default_nettype none
package jpn_pkg;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [15:0] ONE_Q14 = 16'h4000;
  localparam int          SQ_STAGES = 25;  // one root bit per stage
  localparam int          DV_STAGES = 26;  // one quotient bit per stage
  localparam int          Q_DEPTH = 4;
  localparam int          Q_AW = $clog2(Q_DEPTH);

  // Word handed from the front to the back: position and the four
  // weighted rotation sums as sign and magnitude.
  typedef struct packed {
    logic [47:0]       pos;
    logic [3:0]        neg;
    logic [3:0][31:0]  mag;
  } jpn_sum_t;

  // Sideband that travels with an item through the normalizer.
  typedef struct packed {
    logic [47:0]       pos;
    logic [3:0]        neg;
    logic [3:0][23:0]  m;
    logic              zero;
  } jpn_side_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } jpn_qstat_t;

endpackage
`default_nettype wire

FILE: rtl/core/jpn_front.sv
// ----------------------------------------------------------------------------
// jpn_front
// Accepts pose pairs, lerps the position and forms the weighted rotation sums.
// ----------------------------------------------------------------------------
`default_nettype none
module jpn_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic [47:0]       prev_position,
  input  wire logic [63:0]       prev_rotation,
  input  wire logic [47:0]       next_position,
  input  wire logic [63:0]       next_rotation,
  input  wire logic [16:0]       progress,
  input  wire jpn_pkg::jpn_qstat_t qstat,
  output logic                   hold,
  output logic                   push,
  output jpn_pkg::jpn_sum_t      push_word
);
  import jpn_pkg::*;

  logic               v1_r, v2_r, v3_r;
  logic               adv;
  logic [16:0]        t_in;
  logic [16:0]        t1_r;
  logic signed [15:0] p1_r [3];
  logic signed [34:0] d1_r [3];
  logic signed [15:0] a1_r [4];
  logic signed [15:0] b1_r [4];
  logic signed [31:0] ab1_r [4];
  logic [47:0]        pos2_r;
  logic               dneg2_r;
  logic signed [33:0] wa2_r [4];
  logic signed [33:0] tb2_r [4];
  jpn_sum_t           w3_r;
  logic signed [16:0] df [3];
  logic signed [33:0] dot;
  logic signed [35:0] rnd [3];
  logic [47:0]        pos_c;
  logic [16:0]        wa;
  jpn_sum_t           w_c;
  logic signed [34:0] s_c;

  // The whole front moves together; it holds only when its last stage
  // cannot hand its word to the queue.
  assign hold = v3_r && qstat.full;
  assign adv  = !hold;
  assign push = v3_r && !qstat.full;
  assign push_word = w3_r;

  assign t_in = (progress > ONE_Q16) ? ONE_Q16 : progress;
  assign wa   = ONE_Q16 - t1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      df[i] = $signed({next_position[32-16*i+15], next_position[32-16*i +: 16]})
            - $signed({prev_position[32-16*i+15], prev_position[32-16*i +: 16]});
    end
  end

  always_comb begin
    dot = '0;
    for (int i = 0; i < 4; i++) begin
      dot = dot + 34'(ab1_r[i]);
    end
    for (int i = 0; i < 3; i++) begin
      rnd[i] = 36'(d1_r[i]) + 36'sd32768;
      pos_c[32-16*i +: 16] = p1_r[i] + rnd[i][31:16];
    end
  end

  always_comb begin
    w_c.pos = pos2_r;
    for (int i = 0; i < 4; i++) begin
      s_c = dneg2_r ? (35'(wa2_r[i]) - 35'(tb2_r[i])) : (35'(wa2_r[i]) + 35'(tb2_r[i]));
      w_c.neg[i] = s_c[34];
      w_c.mag[i] = s_c[34] ? 32'(-s_c) : s_c[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= take;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r <= t_in;
      for (int i = 0; i < 3; i++) begin
        p1_r[i] <= $signed(prev_position[32-16*i +: 16]);
        d1_r[i] <= df[i] * $signed({1'b0, t_in});
      end
      for (int i = 0; i < 4; i++) begin
        a1_r[i]  <= $signed(prev_rotation[48-16*i +: 16]);
        b1_r[i]  <= $signed(next_rotation[48-16*i +: 16]);
        ab1_r[i] <= $signed(prev_rotation[48-16*i +: 16])
                  * $signed(next_rotation[48-16*i +: 16]);
      end
      pos2_r  <= pos_c;
      dneg2_r <= dot[33];
      for (int i = 0; i < 4; i++) begin
        wa2_r[i] <= $signed({1'b0, wa}) * a1_r[i];
        tb2_r[i] <= $signed({1'b0, t1_r}) * b1_r[i];
      end
      w3_r <= w_c;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/jpn_queue.sv
// ----------------------------------------------------------------------------
// jpn_queue
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module jpn_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire jpn_pkg::jpn_sum_t   push_word,
  output logic                     pop_valid,
  output jpn_pkg::jpn_sum_t        pop_word,
  output jpn_pkg::jpn_qstat_t      qstat
);
  import jpn_pkg::*;

  jpn_sum_t         mem [Q_DEPTH];
  logic [Q_AW-1:0]  wp_r, rp_r;
  logic [Q_AW:0]    cnt_r;
  logic             pop;

  // The back never stalls, so a word leaves as soon as one is present.
  assign pop         = (cnt_r != '0);
  assign pop_valid   = pop;
  assign pop_word    = mem[rp_r];
  assign qstat.full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign qstat.empty = !pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_word;
  end

endmodule
`default_nettype wire

FILE: rtl/core/jpn_isqrt.sv
// ----------------------------------------------------------------------------
// jpn_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module jpn_isqrt (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_v,
  input  wire logic [49:0]       in_x,
  input  wire jpn_pkg::jpn_side_t in_side,
  output logic                   out_v,
  output logic [24:0]            out_root,
  output jpn_pkg::jpn_side_t     out_side
);
  import jpn_pkg::*;

  logic [50:0] x_r   [SQ_STAGES+1];
  logic [50:0] res_r [SQ_STAGES+1];
  jpn_side_t   sd_r  [SQ_STAGES+1];
  logic        v_r   [SQ_STAGES+1];

  always_comb begin
    x_r[0]   = {1'b0, in_x};
    res_r[0] = '0;
    sd_r[0]  = in_side;
    v_r[0]   = in_v;
  end

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    localparam logic [50:0] BIT = 51'd1 << (2 * (SQ_STAGES - 1 - s));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else begin
        v_r[s+1] <= v_r[s];
      end
    end
    always_ff @(posedge clk) begin
      sd_r[s+1] <= sd_r[s];
      if (x_r[s] >= res_r[s] + BIT) begin
        x_r[s+1]   <= x_r[s] - (res_r[s] + BIT);
        res_r[s+1] <= (res_r[s] >> 1) + BIT;
      end else begin
        x_r[s+1]   <= x_r[s];
        res_r[s+1] <= res_r[s] >> 1;
      end
    end
  end

  assign out_v    = v_r[SQ_STAGES];
  assign out_root = res_r[SQ_STAGES][24:0];
  assign out_side = sd_r[SQ_STAGES];

endmodule
`default_nettype wire

FILE: rtl/core/jpn_recip.sv
// ----------------------------------------------------------------------------
// jpn_recip
// Pipelined restoring divide giving floor(2^48 / root).
// ----------------------------------------------------------------------------
`default_nettype none
module jpn_recip (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_v,
  input  wire logic [24:0]       in_root,
  input  wire jpn_pkg::jpn_side_t in_side,
  output logic                   out_v,
  output logic [25:0]            out_y,
  output jpn_pkg::jpn_side_t     out_side
);
  import jpn_pkg::*;

  logic [25:0] rem_r [DV_STAGES+1];
  logic [25:0] q_r   [DV_STAGES+1];
  logic [24:0] d_r   [DV_STAGES+1];
  jpn_side_t   sd_r  [DV_STAGES+1];
  logic        v_r   [DV_STAGES+1];

  // The dividend has its only set bit far above the quotient bits, so the
  // partial remainder starts as that bit shifted down and each step only
  // brings in a zero.
  always_comb begin
    rem_r[0] = 26'd1 << (48 - DV_STAGES);
    q_r[0]   = '0;
    d_r[0]   = in_root;
    sd_r[0]  = in_side;
    v_r[0]   = in_v;
  end

  for (genvar s = 0; s < DV_STAGES; s++) begin : g_stage
    logic [26:0] sh;
    assign sh = {rem_r[s], 1'b0};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else begin
        v_r[s+1] <= v_r[s];
      end
    end
    always_ff @(posedge clk) begin
      sd_r[s+1] <= sd_r[s];
      d_r[s+1]  <= d_r[s];
      if (sh >= {2'b00, d_r[s]}) begin
        rem_r[s+1] <= 26'(sh - {2'b00, d_r[s]});
        q_r[s+1]   <= {q_r[s][24:0], 1'b1};
      end else begin
        rem_r[s+1] <= sh[25:0];
        q_r[s+1]   <= {q_r[s][24:0], 1'b0};
      end
    end
  end

  assign out_v    = v_r[DV_STAGES];
  assign out_y    = q_r[DV_STAGES];
  assign out_side = sd_r[DV_STAGES];

endmodule
`default_nettype wire

FILE: rtl/core/jpn_back.sv
// ----------------------------------------------------------------------------
// jpn_back
// Normalizes the weighted quaternion sum and drives the result word.
// ----------------------------------------------------------------------------
`default_nettype none
module jpn_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_v,
  input  wire jpn_pkg::jpn_sum_t in_word,
  output logic                   out_valid,
  output logic [47:0]            out_pos,
  output logic [63:0]            out_rot,
  output logic                   out_zero
);
  import jpn_pkg::*;

  logic        v1_r, v2_r, v3_r, v4_r, out_valid_r;
  jpn_side_t   sd1_r, sd2_r, sd3_r, sd4_r;
  jpn_side_t   sd1_c;
  logic [31:0] any;
  logic [5:0]  len;
  logic [31:0] ms;
  logic [47:0] sq2_r [4];
  logic [49:0] n3_r;
  logic        sq_v, dv_v;
  logic [24:0] root;
  logic [25:0] y;
  logic [25:0] y3_r;
  jpn_side_t   sq_sd, dv_sd;
  logic [49:0] pr4_r [4];
  logic [49:0] rq;
  logic [15:0] q;
  logic [63:0] rot_c;
  logic [47:0] pos_r;
  logic [63:0] rot_r;
  logic        zero_r;

  // Common power-of-two scale so the largest magnitude has 24 bits.
  always_comb begin
    any = '0;
    for (int i = 0; i < 4; i++) any = any | in_word.mag[i];
    len = '0;
    for (int i = 0; i < 32; i++) begin
      if (any[i]) len = 6'(i + 1);
    end
    sd1_c.pos  = in_word.pos;
    sd1_c.neg  = in_word.neg;
    sd1_c.zero = (any == '0);
    for (int i = 0; i < 4; i++) begin
      ms = (len > 6'd24) ? (in_word.mag[i] >> (len - 6'd24))
                         : (in_word.mag[i] << (6'd24 - len));
      sd1_c.m[i] = ms[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_v;
      v2_r        <= v1_r;
      v3_r        <= dv_v;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
      // v2_r reaches the square-root pipe through vq_r.
    end
  end

  always_ff @(posedge clk) begin
    sd1_r <= sd1_c;
    sd2_r <= sd1_r;
    for (int i = 0; i < 4; i++) sq2_r[i] <= sd1_r.m[i] * sd1_r.m[i];
    n3_r  <= 50'(sq2_r[0]) + 50'(sq2_r[1]) + 50'(sq2_r[2]) + 50'(sq2_r[3]);
    sd3_r <= dv_sd;
    y3_r  <= y;
    for (int i = 0; i < 4; i++) pr4_r[i] <= sd3_r.m[i] * y3_r;
    sd4_r <= sd3_r;
    pos_r  <= sd4_r.pos;
    rot_r  <= sd4_r.zero ? {ONE_Q14, 48'd0} : rot_c;
    zero_r <= sd4_r.zero;
  end

  // The valid flag and sideband are registered once more to line up with the sum of squares before the root pipe.
  logic        vq_r;
  jpn_side_t   sdq_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else begin
      vq_r <= v2_r;
    end
  end
  always_ff @(posedge clk) begin
    sdq_r <= sd2_r;
  end

  jpn_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (vq_r),
    .in_x     (n3_r),
    .in_side  (sdq_r),
    .out_v    (sq_v),
    .out_root (root),
    .out_side (sq_sd)
  );

  jpn_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (sq_v),
    .in_root  (root),
    .in_side  (sq_sd),
    .out_v    (dv_v),
    .out_y    (y),
    .out_side (dv_sd)
  );

  always_comb begin
    rot_c = '0;
    for (int i = 0; i < 4; i++) begin
      rq = pr4_r[i] + (50'd1 << 33);
      q  = rq[49:34];
      if (q > 16'd32767) q = 16'd32767;
      if (sd4_r.neg[i]) q = 16'(-q);
      rot_c[48-16*i +: 16] = q;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos   = pos_r;
  assign out_rot   = rot_r;
  assign out_zero  = zero_r;

endmodule
`default_nettype wire

FILE: rtl/core/joint_pose_nlerp.sv
// ----------------------------------------------------------------------------
// joint_pose_nlerp
// Blends two joint poses: linear position blend, normalized quaternion blend.
// ----------------------------------------------------------------------------
//
//   channel   ports                                  handshake
//   input     in_prev_*, in_next_*, in_progress       start / busy
//   result    out_blended_*, out_zero_length          out_valid strobe
//
// One word is taken per cycle while busy is low. A word passes 61 register
// stages before its out_valid strobe rises: three front stages, the queue,
// three scaling and squaring stages, 25 square-root stages, 26 divide stages
// and three output stages.
// The long root and divide pipelines make up most of those stages; throughput
// is one word per clock.
// Reset is synchronous and clears every valid flag and the queue.
// Results cannot be held off; busy rises only if the queue fills, which
// the back end, draining one word each cycle, never lets happen.
`default_nettype none
module joint_pose_nlerp (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [47:0] in_prev_position,
  input  wire logic [63:0] in_prev_rotation,
  input  wire logic [47:0] in_next_position,
  input  wire logic [63:0] in_next_rotation,
  input  wire logic [16:0] in_progress,
  output logic             out_valid,
  output logic [47:0]      out_blended_position,
  output logic [63:0]      out_blended_rotation,
  output logic             out_zero_length
);
  import jpn_pkg::*;

  logic        take;
  logic        hold;
  logic        push;
  jpn_sum_t    push_word;
  logic        pop_valid;
  jpn_sum_t    pop_word;
  jpn_qstat_t  qstat;

  // A word is accepted whenever start meets a free front end.
  assign busy = hold;
  assign take = start && !hold;

  jpn_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .prev_position (in_prev_position),
    .prev_rotation (in_prev_rotation),
    .next_position (in_next_position),
    .next_rotation (in_next_rotation),
    .progress      (in_progress),
    .qstat         (qstat),
    .hold          (hold),
    .push          (push),
    .push_word     (push_word)
  );

  jpn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop_valid (pop_valid),
    .pop_word  (pop_word),
    .qstat     (qstat)
  );

  jpn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (pop_valid),
    .in_word   (pop_word),
    .out_valid (out_valid),
    .out_pos   (out_blended_position),
    .out_rot   (out_blended_rotation),
    .out_zero  (out_zero_length)
  );

  // A zero-length blend must come out as the identity rotation.
  a_zero_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |-> out_blended_rotation == {ONE_Q14, 48'd0})
    else $error("zero-length result is not the identity");

  // The front only stalls while the queue is full.
  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> qstat.full)
    else $error("busy without a full queue");

  // The queue never reports full and empty at once.
  a_q_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue status inconsistent");

  // Reset leaves no result strobe behind.
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule
`default_nettype wire

FILE: test/joint_pose_nlerp_tb.sv
// ----------------------------------------------------------------------------
// joint_pose_nlerp_tb
// Self-checking bench for the joint pose blender: directed corner words, then
// random words with random sender gaps, checked against an in-bench predictor.
// ----------------------------------------------------------------------------
`default_nettype none

// Scoreboard: predicts the blended pose for each accepted word and compares
// each strobed result against the oldest prediction.
class pose_blend_board;

  typedef struct {
    logic [47:0] position;
    logic [63:0] rotation;
    logic        zero_len;
  } pose_t;

  pose_t pending[$];
  int    mismatches;
  int    results_seen;
  int    zero_seen;

  function new();
    mismatches   = 0;
    results_seen = 0;
    zero_seen    = 0;
  endfunction

  static function longint half_of(logic [63:0] v, int sh);
    logic signed [15:0] h;
    h = v[sh +: 16];
    return longint'(h);
  endfunction

  // Floor division by 2^s for signed values.
  static function longint floor_div(longint v, int s);
    return v >>> s;
  endfunction

  static function longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= root + bitv) begin
        x    = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function pose_t blend(logic [47:0] pp, logic [63:0] pr, logic [47:0] np,
                        logic [63:0] nr, logic [16:0] prog);
    pose_t           res;
    longint          t;
    longint          p;
    longint          d;
    longint          a[4];
    longint          b[4];
    longint          s[4];
    longint          dot;
    longint          wa;
    longint          wb;
    longint unsigned m[4];
    longint unsigned any;
    longint unsigned n2;
    longint unsigned r;
    longint unsigned y;
    longint unsigned q;
    int              len;
    logic [15:0]     c;
    t = (prog > 17'd65536) ? 65536 : longint'(prog);
    for (int i = 0; i < 3; i++) begin
      p = half_of({16'd0, pp}, 32 - 16 * i);
      d = floor_div((half_of({16'd0, np}, 32 - 16 * i) - p) * t + 32768, 16);
      c = 16'(p + d);
      res.position[32 - 16 * i +: 16] = c;
    end
    dot = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = half_of(pr, 48 - 16 * i);
      b[i] = half_of(nr, 48 - 16 * i);
      dot += a[i] * b[i];
    end
    wa  = 65536 - t;
    wb  = (dot < 0) ? -t : t;
    any = 0;
    for (int i = 0; i < 4; i++) begin
      s[i] = wa * a[i] + wb * b[i];
      m[i] = (s[i] < 0) ? -s[i] : s[i];
      any |= m[i];
    end
    if (any == 0) begin
      res.rotation = {16'h4000, 48'd0};
      res.zero_len = 1'b1;
      return res;
    end
    len = 0;
    for (int i = 0; i < 40; i++)
      if (any[i]) len = i + 1;
    n2 = 0;
    for (int i = 0; i < 4; i++) begin
      if (len > 24) m[i] = m[i] >> (len - 24);
      else m[i] = m[i] << (24 - len);
      n2 += m[i] * m[i];
    end
    r = int_sqrt(n2);
    if (r == 0) r = 1;
    y = (64'd1 << 48) / r;
    for (int i = 0; i < 4; i++) begin
      q = (m[i] * y + (64'd1 << 33)) >> 34;
      if (q > 32767) q = 32767;
      if (s[i] < 0) q = (64'h10000 - q) & 64'hFFFF;
      res.rotation[48 - 16 * i +: 16] = q[15:0];
    end
    res.zero_len = 1'b0;
    return res;
  endfunction

  function void note_word(logic [47:0] pp, logic [63:0] pr, logic [47:0] np,
                          logic [63:0] nr, logic [16:0] prog);
    pending.insert(pending.size(), blend(pp, pr, np, nr, prog));
  endfunction

  function void check_result(logic [47:0] pos, logic [63:0] rot, logic zl);
    pose_t e;
    results_seen++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: result with nothing pending");
      return;
    end
    e = pending.pop_front();
    if (zl) zero_seen++;
    if (pos !== e.position || rot !== e.rotation || zl !== e.zero_len) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result %0d exp pos=%h rot=%h zl=%b got pos=%h rot=%h zl=%b",
                 results_seen, e.position, e.rotation, e.zero_len, pos, rot, zl);
    end
  endfunction

endclass

module joint_pose_nlerp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 630;
  localparam int IDLE_LIMIT   = 5000;
  localparam int TAIL_CYCLES  = 80;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [47:0] in_prev_position;
  logic [63:0] in_prev_rotation;
  logic [47:0] in_next_position;
  logic [63:0] in_next_rotation;
  logic [16:0] in_progress;
  logic        out_valid;
  logic [47:0] out_blended_position;
  logic [63:0] out_blended_rotation;
  logic        out_zero_length;

  pose_blend_board board;
  int              idle_cycles;
  int              words_sent;

  joint_pose_nlerp dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_prev_position    (in_prev_position),
    .in_prev_rotation    (in_prev_rotation),
    .in_next_position    (in_next_position),
    .in_next_rotation    (in_next_rotation),
    .in_progress         (in_progress),
    .out_valid           (out_valid),
    .out_blended_position(out_blended_position),
    .out_blended_rotation(out_blended_rotation),
    .out_zero_length     (out_zero_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results are strobed and cannot be stalled, so every strobe is checked
  // straight away. The watchdog counts cycles in which no word moves on
  // either side.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_result(out_blended_position, out_blended_rotation, out_zero_length);
    end
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: watchdog expired with %0d results pending", board.pending.size());
      $display("FAIL joint_pose_nlerp");
      $finish;
    end
  end

  // Presents one word and holds it until the block takes it. The start line
  // stays high when the next word follows without a gap.
  task automatic send_word(logic [47:0] pp, logic [63:0] pr, logic [47:0] np,
                           logic [63:0] nr, logic [16:0] prog);
    start            <= 1'b1;
    in_prev_position <= pp;
    in_prev_rotation <= pr;
    in_next_position <= np;
    in_next_rotation <= nr;
    in_progress      <= prog;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_word(pp, pr, np, nr, prog);
    words_sent++;
  endtask

  // Drops start for a random gap: mostly none or short, now and then long.
  task automatic sender_gap();
    int n;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) n = 0;
    else if (pick < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 70);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // A random unit-ish quaternion: small components with one near 16'h4000 in
  // magnitude, so the blend lands in the typical normalized range.
  function automatic logic [63:0] near_unit_quat();
    logic [63:0] q;
    int          big;
    q   = '0;
    big = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) begin
      if (i == big) q[i * 16 +: 16] = $urandom_range(0, 1)
                                      ? 16'(32'h4000 - $urandom_range(0, 3000))
                                      : 16'(32'hC000 + $urandom_range(0, 3000));
      else q[i * 16 +: 16] = 16'($urandom_range(0, 4000) - 2000);
    end
    return q;
  endfunction

  function automatic logic [16:0] rand_progress();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 17'($urandom_range(65537, 131071));
    if (pick == 1) return $urandom_range(0, 1) ? 17'd0 : 17'd65536;
    return 17'($urandom_range(0, 65536));
  endfunction

  initial begin
    logic [63:0] qa;
    logic [63:0] qb;
    board            = new();
    idle_cycles      = 0;
    words_sent       = 0;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_prev_position = '0;
    in_prev_rotation = '0;
    in_next_position = '0;
    in_next_rotation = '0;
    in_progress      = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: field extremes, progress at zero, one, and saturated,
    // a negative dot product, a zero-length blend, and non-unit quaternions.
    send_word('0, '0, '0, '0, 17'd0);
    send_word('0, {16'h4000, 48'd0}, '0, {16'h4000, 48'd0}, 17'd32768);
    send_word({3{16'h7FFF}}, {16'h4000, 48'd0}, {3{16'h8000}}, {16'hC000, 48'd0},
              17'd32768);
    send_word({3{16'h8000}}, {4{16'h7FFF}}, {3{16'h7FFF}}, {4{16'h8000}}, 17'd65536);
    send_word({3{16'h7FFF}}, {4{16'h8000}}, {3{16'h8000}}, {4{16'h8000}}, 17'd131071);
    send_word({3{16'hFFFF}}, {4{16'hFFFF}}, {3{16'h0001}}, {4{16'h0001}}, 17'd65537);
    send_word({16'h1234, 16'h8001, 16'h7FFE}, {16'h2D41, 16'h2D41, 32'd0},
              {16'hEDCC, 16'h0100, 16'h8000}, {16'hD2BF, 16'h2D41, 32'd0}, 17'd1);
    send_word('0, {16'h0000, 16'h4000, 32'd0}, '0, {16'h0000, 16'hC000, 32'd0},
              17'd65535);
    send_word('0, {16'd1, 48'd0}, '0, {16'd1, 48'd0}, 17'd1);
    send_word('0, {16'h0, 16'h0, 16'h0, 16'h0001}, '0, 64'd0, 17'd40000);
    send_word('0, {16'h4000, 48'd0}, '0, {16'h0000, 16'h4000, 32'd0}, 17'd32768);
    send_word(48'hAAAA_5555_AAAA, 64'h5555_AAAA_5555_AAAA, 48'h5555_AAAA_5555,
              64'hAAAA_5555_AAAA_5555, 17'h15555);
    for (int i = 0; i < 8; i++) begin
      send_word(rand64(), rand64(), rand64(), rand64(), rand_progress());
      sender_gap();
    end

    // Pause until every outstanding word has come back.
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);

    // Random part: mostly random positions with near-unit rotations, the rest
    // fully random bit patterns. A stretch in the middle runs without gaps.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_word(rand64(), rand64(), rand64(), rand64(), 17'($urandom()));
      end else begin
        qa = near_unit_quat();
        qb = ($urandom_range(0, 7) == 0) ? qa : near_unit_quat();
        send_word(rand64(), qa, rand64(), qb, rand_progress());
      end
      if (i < 200 || i > 320) sender_gap();
      if (i == 400) begin
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Blended %0d pose words, %0d results checked, %0d zero-length blends.",
             words_sent, board.results_seen, board.zero_seen);
    $display("Mismatches: %0d", board.mismatches);
    if (board.mismatches == 0) begin
      $display("PASS joint_pose_nlerp");
    end else begin
      $display("FAIL joint_pose_nlerp");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/jpn_pkg.sv
rtl/core/jpn_front.sv
rtl/core/jpn_queue.sv
rtl/core/jpn_isqrt.sv
rtl/core/jpn_recip.sv
rtl/core/jpn_back.sv
rtl/core/joint_pose_nlerp.sv
test/joint_pose_nlerp_tb.sv
